// ===== rtl/core/rewm_pkg.sv =====
// ----------------------------------------------------------------------------
// rewm_pkg
// Shared constants, types and helpers of the ring exclusion walker move core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rewm_pkg;

  localparam int RingSites      = 64;
  localparam int WeightFracBits = 32;

  localparam int OccW     = 64;
  localparam int DrawW    = 32;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 1;
  localparam int WeightW  = 39;
  localparam int CntW     = 6;
  localparam int SrchW    = WeightW + 1;
  localparam int PpW      = WeightW + DrawW / 2 + 1;

  localparam int GroupSize = 8;
  localparam int NumGroups = (RingSites + GroupSize - 1) / GroupSize;
  localparam int GrpCntW   = 4;

  localparam logic [OccW-1:0] RingMask =
      (RingSites >= OccW) ? {OccW{1'b1}} : ((OccW'(1) << RingSites) - OccW'(1));
  localparam logic [WeightW-1:0] WeightOne = WeightW'(1) << WeightFracBits;

  localparam logic [CfgW-1:0] HopWeightRst = 32'd90822;
  localparam logic [CfgW-1:0] LeaveRateRst = 32'd671089;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHopWeight = 1'b0,
    CfgLeaveRate = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [OccW-1:0]                 occ;
    logic [RingSites-1:0]            hop;
    logic [RingSites-1:0][CntW-1:0]  rank;
  } site_t;

  function automatic int unsigned next_site(int unsigned j);
    return (j + 1 >= RingSites) ? 0 : j + 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rewm_rank.sv =====
// ----------------------------------------------------------------------------
// rewm_rank
// Finds legal hops and gives each one its rank in site order (3 stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rewm_rank import rewm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [OccW-1:0]      occ_i,
  input  wire logic [DrawW-1:0]     draw_i,
  output logic                      valid_o,
  output site_t                     site_o,
  output logic [CntW-1:0]           hops_o,
  output logic [DrawW-1:0]          draw_o
);

  logic                 v1_q, v2_q, v3_q;
  logic [OccW-1:0]      occ1_q, occ2_q;
  logic [RingSites-1:0] hop1_q, hop2_q;
  logic [DrawW-1:0]     draw1_q, draw2_q, draw3_q;
  logic [RingSites-1:0][GrpCntW-1:0] lp_d, lp2_q;
  site_t                site3_d, site3_q;
  logic [CntW-1:0]      hops3_d, hops3_q;
  logic [OccW-1:0]      occ_m;
  logic [RingSites-1:0] hop_d;

  always_comb begin
    occ_m = occ_i & RingMask;
    for (int j = 0; j < RingSites; j++) begin
      hop_d[j] = occ_m[j] & ~occ_m[next_site(j)];
    end
  end

  // inclusive count of hops inside each group of sites
  always_comb begin
    logic [GrpCntW-1:0] run;
    run = '0;
    for (int j = 0; j < RingSites; j++) begin
      if (j % GroupSize == 0) begin
        run = '0;
      end
      run     = run + GrpCntW'(hop1_q[j]);
      lp_d[j] = run;
    end
  end

  always_comb begin
    logic [CntW-1:0] off;
    logic [NumGroups-1:0][CntW-1:0] grp_off;
    off = '0;
    for (int g = 0; g < NumGroups; g++) begin
      grp_off[g] = off;
      off = off + CntW'(lp2_q[(g * GroupSize + GroupSize - 1 < RingSites) ?
                              g * GroupSize + GroupSize - 1 : RingSites - 1]);
    end
    hops3_d      = off;
    site3_d.occ  = occ2_q;
    site3_d.hop  = hop2_q;
    for (int j = 0; j < RingSites; j++) begin
      site3_d.rank[j] = grp_off[j / GroupSize] + CntW'(lp2_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      occ1_q  <= occ_m;
      hop1_q  <= hop_d;
      draw1_q <= draw_i;
      occ2_q  <= occ1_q;
      hop2_q  <= hop1_q;
      draw2_q <= draw1_q;
      lp2_q   <= lp_d;
      site3_q <= site3_d;
      hops3_q <= hops3_d;
      draw3_q <= draw2_q;
    end
  end

  assign valid_o = v3_q;
  assign site_o  = site3_q;
  assign hops_o  = hops3_q;
  assign draw_o  = draw3_q;

  a_hops_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> hops3_q <= CntW'(RingSites / 2))
    else $error("hop count above half the ring");

endmodule

`default_nettype wire

// ===== rtl/core/rewm_target.sv =====
// ----------------------------------------------------------------------------
// rewm_target
// Column sum of the entry weights and the scaled draw target (4 stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rewm_target import rewm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire site_t                site_i,
  input  wire logic [CntW-1:0]      hops_i,
  input  wire logic [DrawW-1:0]     draw_i,
  input  wire logic [CfgW-1:0]      hop_weight_i,
  input  wire logic [CfgW-1:0]      leave_rate_i,
  output logic                      valid_o,
  output site_t                     site_o,
  output logic [CntW-1:0]           hops_o,
  output logic [WeightW-1:0]        sum_o,
  output logic [WeightW-1:0]        target_o
);

  localparam int HalfW = DrawW / 2;

  logic                v1_q, v2_q, v3_q, v4_q;
  site_t               site1_q, site2_q, site3_q, site4_q;
  logic [CntW-1:0]     hops1_q, hops2_q, hops3_q, hops4_q;
  logic [DrawW-1:0]    draw1_q, draw2_q;
  logic [WeightW-1:0]  taken1_q, hopsum1_q;
  logic [WeightW-1:0]  stay2_d, sum2_q, sum3_q, sum4_q, target4_q;
  logic [PpW-1:0]      p3_q, q3_q;

  always_comb begin
    if (taken1_q < WeightOne) begin
      stay2_d = WeightOne - taken1_q;
    end else begin
      stay2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      site1_q   <= site_i;
      hops1_q   <= hops_i;
      draw1_q   <= draw_i;
      taken1_q  <= WeightW'(hops_i) * WeightW'(leave_rate_i);
      hopsum1_q <= WeightW'(hops_i) * WeightW'(hop_weight_i);

      site2_q   <= site1_q;
      hops2_q   <= hops1_q;
      draw2_q   <= draw1_q;
      sum2_q    <= hopsum1_q + stay2_d;

      site3_q   <= site2_q;
      hops3_q   <= hops2_q;
      sum3_q    <= sum2_q;
      p3_q      <= PpW'(sum2_q) * PpW'(draw2_q[DrawW-1:HalfW]);
      q3_q      <= PpW'(sum2_q) * PpW'(draw2_q[HalfW-1:0]);

      site4_q   <= site3_q;
      hops4_q   <= hops3_q;
      sum4_q    <= sum3_q;
      target4_q <= WeightW'((p3_q + (q3_q >> HalfW)) >> HalfW);
    end
  end

  assign valid_o  = v4_q;
  assign site_o   = site4_q;
  assign hops_o   = hops4_q;
  assign sum_o    = sum4_q;
  assign target_o = target4_q;

  a_no_hop_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && hops2_q == '0 |-> sum2_q == WeightOne)
    else $error("column sum without hops is not one");

  a_target_le_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> target4_q <= sum4_q)
    else $error("target above column sum");

endmodule

`default_nettype wire

// ===== rtl/core/rewm_search.sv =====
// ----------------------------------------------------------------------------
// rewm_search
// Finds how many hops the running sum needs to reach the target, one count
// bit per stage, then applies the chosen hop in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rewm_search import rewm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire site_t                site_i,
  input  wire logic [CntW-1:0]      hops_i,
  input  wire logic [WeightW-1:0]   sum_i,
  input  wire logic [WeightW-1:0]   target_i,
  input  wire logic [CfgW-1:0]      hop_weight_i,
  output logic                      valid_o,
  output logic [OccW-1:0]           next_occ_o,
  output logic [WeightW-1:0]        weight_o,
  output logic [CntW-1:0]           hops_o,
  output logic                      moved_o
);

  typedef struct packed {
    site_t               site;
    logic [CntW-1:0]     hops;
    logic [WeightW-1:0]  sum;
    logic [WeightW-1:0]  target;
    logic [SrchW-1:0]    acc;
    logic [CntW-1:0]     kp;
  } step_t;

  step_t              step_in;
  step_t              stg_q [CntW];
  logic [CntW-1:0]    vld_q;

  assign step_in = '{site: site_i, hops: hops_i, sum: sum_i, target: target_i,
                     acc: '0, kp: '0};

  // largest count whose running sum stays below the target, MSB first
  for (genvar s = 0; s < CntW; s++) begin : g_step
    localparam int B = CntW - 1 - s;
    step_t            prev;
    logic             prev_v;
    step_t            nxt;
    logic [SrchW-1:0] cand;

    if (s == 0) begin : g_first
      assign prev   = step_in;
      assign prev_v = valid_i;
    end else begin : g_rest
      assign prev   = stg_q[s-1];
      assign prev_v = vld_q[s-1];
    end

    always_comb begin
      nxt  = prev;
      cand = prev.acc + (SrchW'(hop_weight_i) << B);
      if (cand < SrchW'(prev.target)) begin
        nxt.acc   = cand;
        nxt.kp[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s] <= nxt;
      end
    end
  end

  step_t            last;
  logic [CntW:0]    pick;
  logic             moved_d;
  logic [OccW-1:0]  next_d;
  logic             out_valid_q;
  logic [OccW-1:0]  next_q;
  logic [WeightW-1:0] weight_q;
  logic [CntW-1:0]  hops_q;
  logic             moved_q;

  assign last = stg_q[CntW-1];

  always_comb begin
    pick    = {1'b0, last.kp} + (CntW + 1)'(1);
    moved_d = (pick <= {1'b0, last.hops});
    next_d  = last.site.occ;
    for (int j = 0; j < RingSites; j++) begin
      if (moved_d && last.site.hop[j] && last.site.rank[j] == pick[CntW-1:0]) begin
        next_d[j]            = 1'b0;
        next_d[next_site(j)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= vld_q[CntW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      next_q   <= next_d;
      weight_q <= last.sum;
      hops_q   <= last.hops;
      moved_q  <= moved_d;
    end
  end

  assign valid_o    = out_valid_q;
  assign next_occ_o = next_q;
  assign weight_o   = weight_q;
  assign hops_o     = hops_q;
  assign moved_o    = moved_q;

  a_move_needs_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && moved_q |-> hops_q != '0)
    else $error("move chosen without a legal hop");

  a_particles_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CntW-1] |-> $countones(next_d) == $countones(last.site.occ))
    else $error("particle count changed by move");

endmodule

`default_nettype wire

// ===== rtl/core/ring_exclusion_walker_move_core.sv =====
// ----------------------------------------------------------------------------
// ring_exclusion_walker_move_core
// One Monte Carlo move of a ring exclusion walker per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tdata carries the walker occupancy and a Q0.32 uniform
//   draw. Output stream: the occupancy after the move, the Q7.32 column sum,
//   the number of legal hops and a moved flag, one transaction per input.
//   Configuration: write hop_weight (index 0) or leave_rate (index 1) with
//   cfg_we_i while the pipeline is empty; there is no read-back.
//   From input to output valid the pipeline holds 3 stages of hop rank
//   counting, 4 stages of weight and target arithmetic, 6 stages of the
//   hop count search (one count bit each) and the output register.
//   Throughput is one transaction per cycle while the receiver does not stall.
//   Reset empties the pipeline and loads the default register values.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops; s_axis_tready stays high while the output register is empty or
//   being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_exclusion_walker_move_core import rewm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,

  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [95:0]          s_axis_tdata,   // occupancy[63:0], uniform_draw[95:64]

  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [111:0]              m_axis_tdata    // next_occupancy[63:0],
                                                    // walker_weight[102:64],
                                                    // hop_total[108:103], moved[109]
);

  logic [CfgW-1:0]    hop_weight_q, leave_rate_q;
  logic               en;

  logic               rk_valid;
  site_t              rk_site;
  logic [CntW-1:0]    rk_hops;
  logic [DrawW-1:0]   rk_draw;

  logic               tg_valid;
  site_t              tg_site;
  logic [CntW-1:0]    tg_hops;
  logic [WeightW-1:0] tg_sum, tg_target;

  logic [OccW-1:0]    next_occ;
  logic [WeightW-1:0] weight;
  logic [CntW-1:0]    hops;
  logic               moved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_weight_q <= HopWeightRst;
      leave_rate_q <= LeaveRateRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgHopWeight: hop_weight_q <= cfg_data_i;
        CfgLeaveRate: leave_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  rewm_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .occ_i   (s_axis_tdata[OccW-1:0]),
    .draw_i  (s_axis_tdata[OccW+DrawW-1:OccW]),
    .valid_o (rk_valid),
    .site_o  (rk_site),
    .hops_o  (rk_hops),
    .draw_o  (rk_draw)
  );

  rewm_target u_target (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (rk_valid),
    .site_i       (rk_site),
    .hops_i       (rk_hops),
    .draw_i       (rk_draw),
    .hop_weight_i (hop_weight_q),
    .leave_rate_i (leave_rate_q),
    .valid_o      (tg_valid),
    .site_o       (tg_site),
    .hops_o       (tg_hops),
    .sum_o        (tg_sum),
    .target_o     (tg_target)
  );

  rewm_search u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (tg_valid),
    .site_i       (tg_site),
    .hops_i       (tg_hops),
    .sum_i        (tg_sum),
    .target_i     (tg_target),
    .hop_weight_i (hop_weight_q),
    .valid_o      (m_axis_tvalid),
    .next_occ_o   (next_occ),
    .weight_o     (weight),
    .hops_o       (hops),
    .moved_o      (moved)
  );

  assign m_axis_tdata = {2'b00, moved, hops, weight, next_occ};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
